FILE: rtl/bdq_pkg.sv
// Shared types and defaults for the bounded deque with positional insert.
package bdq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Port widths of the command and result fields
	localparam int CMD_W   = 3;
	localparam int POS_W   = 5;
	localparam int DIN_W   = 32;
	localparam int DOUT_W  = 32;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND    = 3'd0,
		CMD_POP_HEAD  = 3'd1,
		CMD_POP_TAIL  = 3'd2,
		CMD_INSERT    = 3'd3,
		CMD_PEEK_HEAD = 3'd4,
		CMD_PEEK_TAIL = 3'd5
	} cmd_t;

	// Broadcast to every cell of the chain
	typedef struct packed {
		logic ins;  // open a gap at the insert index and load the new word
		logic pop;  // every cell takes its right neighbor's word; the last cell keeps its own
	} cell_ctrl_t;

endpackage

FILE: rtl/bdq_cell.sv
// One storage cell of the shift chain.
module bdq_cell import bdq_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int IW         = 5,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  cell_ctrl_t            ctrl,
	input  logic [IW-1:0]         at_idx,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	output logic [DATA_WIDTH-1:0] word
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] word_nxt;

	always_comb begin
		word_nxt = word_q;
		if (ctrl.ins) begin
			if (MY_IDX == at_idx) begin
				word_nxt = din;
			end else if (MY_IDX > at_idx) begin
				word_nxt = left_word;
			end
		end else if (ctrl.pop) begin
			word_nxt = right_word;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_nxt;
	end

	assign word = word_q;

endmodule

FILE: rtl/bounded_deque_with_insert.sv
// Top level: bounded deque with positional insert, built as a chain of shift cells.
//
//  channel   handshake          payload
//  --------  -----------------  -------------------------------
//  command   start / busy       command, position, data_in
//  result    strobe             ok, data_out, count
//
// The cells shift or load at the accepting edge
// and the result shows on the next cycle, so commands may follow back to back.
// busy is tied low, since the cell chain never needs to hold a command.
// The receiver cannot stall: each result is valid for exactly one cycle.
// Reset clears the count and the strobe; cell contents stay unknown until written.
module bounded_deque_with_insert import bdq_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   command,
	input  logic [POS_W-1:0]   position,
	input  logic [DIN_W-1:0]   data_in,
	output logic               strobe,
	output logic               ok,
	output logic [DOUT_W-1:0]  data_out,
	output logic [COUNT_W-1:0] count
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_nxt;
	logic                  strobe_q;
	logic                  ok_q;
	logic                  ok_nxt;
	logic [DATA_WIDTH-1:0] dout_q;
	logic [DATA_WIDTH-1:0] dout_nxt;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  pos_ok;
	logic [CW-1:0]         tail_idx;
	logic [CW-1:0]         at_idx;
	logic [DATA_WIDTH-1:0] din;
	logic [DATA_WIDTH-1:0] head_word;
	logic [DATA_WIDTH-1:0] tail_word;
	cell_ctrl_t            ctrl;

	logic [DATA_WIDTH-1:0] words [DEPTH];

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign full     = (cnt_q == FULL_CNT);
	assign empty    = (cnt_q == '0);
	assign pos_ok   = (CMPW'(position) <= CMPW'(cnt_q));
	assign tail_idx = cnt_q - CW'(1);
	assign din      = DATA_WIDTH'(data_in);
	assign head_word = words[0];

	// Select the tail word: only the cell whose index matches contributes
	always_comb begin
		tail_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (tail_idx == CW'(i)) begin
				tail_word = tail_word | words[i];
			end
		end
	end

	always_comb begin
		ctrl     = '0;
		at_idx   = cnt_q;
		cnt_nxt  = cnt_q;
		ok_nxt   = 1'b0;
		dout_nxt = '0;
		case (cmd_t'(command))
			CMD_APPEND: begin
				if (!full) begin
					ctrl.ins = accept;
					cnt_nxt  = cnt_q + CW'(1);
					ok_nxt   = 1'b1;
				end
			end
			CMD_INSERT: begin
				at_idx = CW'(position);
				if (!full && pos_ok) begin
					ctrl.ins = accept;
					cnt_nxt  = cnt_q + CW'(1);
					ok_nxt   = 1'b1;
				end
			end
			CMD_POP_HEAD: begin
				if (!empty) begin
					ctrl.pop = accept;
					cnt_nxt  = cnt_q - CW'(1);
					ok_nxt   = 1'b1;
					dout_nxt = head_word;
				end
			end
			CMD_POP_TAIL: begin
				if (!empty) begin
					cnt_nxt  = cnt_q - CW'(1);
					ok_nxt   = 1'b1;
					dout_nxt = tail_word;
				end
			end
			CMD_PEEK_HEAD: begin
				if (!empty) begin
					ok_nxt   = 1'b1;
					dout_nxt = head_word;
				end
			end
			CMD_PEEK_TAIL: begin
				if (!empty) begin
					ok_nxt   = 1'b1;
					dout_nxt = tail_word;
				end
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= accept;
			if (accept) begin
				cnt_q <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q   <= ok_nxt;
			dout_q <= dout_nxt;
		end
	end

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic [DATA_WIDTH-1:0] left_word;
			logic [DATA_WIDTH-1:0] right_word;
			if (g == 0) begin : g_first
				assign left_word = din;
			end else begin : g_mid_l
				assign left_word = words[g-1];
			end
			if (g == DEPTH - 1) begin : g_last
				assign right_word = words[g];
			end else begin : g_mid_r
				assign right_word = words[g+1];
			end
			bdq_cell #(
				.DATA_WIDTH (DATA_WIDTH),
				.IW         (CW),
				.INDEX      (g)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.at_idx     (at_idx),
				.din        (din),
				.left_word  (left_word),
				.right_word (right_word),
				.word       (words[g])
			);
		end
	endgenerate

	assign strobe   = strobe_q;
	assign ok       = ok_q;
	assign data_out = DOUT_W'(dout_q);
	assign count    = COUNT_W'(cnt_q);

endmodule

FILE: rtl/bdq_checker.sv
// Port-level checks for the bounded deque, bound to the top level.
module bdq_checker import bdq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic [CMD_W-1:0]   command,
	input logic               strobe,
	input logic               ok,
	input logic [DOUT_W-1:0]  data_out,
	input logic [COUNT_W-1:0] count
);

	// Each accepted transaction yields its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("no result after accepted transaction");

	// A failed command returns a zero word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !ok) |-> (data_out == '0))
		else $error("nonzero data on failed command");

	// A failed command leaves the count alone
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) ##1 (strobe && !ok) |-> (count == $past(count)))
		else $error("count moved on failed command");

	// A successful append or insert advances the count by one
	a_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (command == CMD_APPEND || command == CMD_INSERT)) ##1
		(strobe && ok) |-> (count == $past(count) + COUNT_W'(1)))
		else $error("count did not advance on insert");

endmodule

bind bounded_deque_with_insert bdq_checker u_bdq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.command  (command),
	.strobe   (strobe),
	.ok       (ok),
	.data_out (data_out),
	.count    (count)
);

FILE: tb/bounded_deque_with_insert_test.sv
// Self-checking testbench for the bounded deque with positional insert.
`timescale 1ns / 1ps

module bounded_deque_with_insert_test;
	import bdq_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 100000;
	localparam int PHASE_ITEMS = 200;

	// Codes the block must ignore
	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [DIN_W-1:0] word;
		int               idle_pct;
	} deque_cmd_t;

	typedef struct {
		logic               ok;
		logic [DOUT_W-1:0]  data;
		logic [COUNT_W-1:0] count;
	} deque_result_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic [CMD_W-1:0]   command  = CMD_APPEND;
	logic [POS_W-1:0]   position = '0;
	logic [DIN_W-1:0]   data_in  = '0;
	logic               busy;
	logic               strobe;
	logic               ok;
	logic [DOUT_W-1:0]  data_out;
	logic [COUNT_W-1:0] count;

	deque_cmd_t    cmd_queue[$];
	deque_cmd_t    next_cmd;
	deque_result_t pending_results[$];
	deque_result_t want;
	deque_result_t exp_res;
	logic [DIN_W-1:0] list_words[$];

	int items_total;
	int accepted_total;
	int mismatches;
	int cycle_count;
	int gen_count;
	int cmd_tally[8];
	int ok_tally;
	int full_refusals;
	int empty_refusals;

	bounded_deque_with_insert dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.position (position),
		.data_in  (data_in),
		.strobe   (strobe),
		.ok       (ok),
		.data_out (data_out),
		.count    (count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one command to the list and return the result it should produce
	function automatic deque_result_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [DIN_W-1:0] word);
		deque_result_t res;
		int            held;
		res  = '{ok: 1'b0, data: '0, count: '0};
		held = list_words.size();
		case (cmd)
			CMD_APPEND: begin
				if (held < LIST_DEPTH) begin
					list_words.push_back(word);
					res.ok = 1'b1;
				end else
					full_refusals++;
			end
			CMD_POP_HEAD: begin
				if (held > 0) begin
					res.data = list_words.pop_front();
					res.ok   = 1'b1;
				end else
					empty_refusals++;
			end
			CMD_POP_TAIL: begin
				if (held > 0) begin
					res.data = list_words.pop_back();
					res.ok   = 1'b1;
				end else
					empty_refusals++;
			end
			CMD_INSERT: begin
				if (held >= LIST_DEPTH)
					full_refusals++;
				else if (int'(pos) <= held) begin
					list_words.insert(int'(pos), word);
					res.ok = 1'b1;
				end
			end
			CMD_PEEK_HEAD: begin
				if (held > 0) begin
					res.data = list_words[0];
					res.ok   = 1'b1;
				end else
					empty_refusals++;
			end
			CMD_PEEK_TAIL: begin
				if (held > 0) begin
					res.data = list_words[held-1];
					res.ok   = 1'b1;
				end else
					empty_refusals++;
			end
			default: ;
		endcase
		res.count = COUNT_W'(list_words.size());
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [DOUT_W-1:0] got,
			input logic [DOUT_W-1:0] exp_val);
		$display("MISMATCH at %0t: %s got %0h, expected %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	// Queue a command; track the count so insert positions can aim at valid slots
	task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [DIN_W-1:0] word, input int idle_pct);
		cmd_queue.push_back('{cmd: cmd, pos: pos, word: word, idle_pct: idle_pct});
		case (cmd)
			CMD_APPEND:
				if (gen_count < LIST_DEPTH) gen_count++;
			CMD_INSERT:
				if (gen_count < LIST_DEPTH && int'(pos) <= gen_count) gen_count++;
			CMD_POP_HEAD, CMD_POP_TAIL:
				if (gen_count > 0) gen_count--;
			default: ;
		endcase
	endtask

	function automatic logic [DIN_W-1:0] rand_word();
		int pick;
		pick = $urandom_range(19);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return '1;
		return $urandom();
	endfunction

	task automatic add_random_phase(input int idle_pct);
		int               issued;
		int               run_left;
		int               mode;
		int               r;
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		issued   = 0;
		run_left = 0;
		mode     = 0;
		while (issued < PHASE_ITEMS) begin
			if (run_left == 0) begin
				run_left = $urandom_range(30, 8);
				mode     = $urandom_range(2);
			end
			r   = $urandom_range(99);
			pos = POS_W'($urandom_range(gen_count, 0));
			if (r < 6) begin
				// noise: any code, any position
				cmd = CMD_W'($urandom_range(7));
				pos = POS_W'($urandom_range(31));
			end else if (mode == 0) begin
				if (r < 45)
					cmd = CMD_APPEND;
				else if (r < 85)
					cmd = CMD_INSERT;
				else if (r < 92)
					cmd = CMD_PEEK_HEAD;
				else
					cmd = CMD_PEEK_TAIL;
			end else if (mode == 1) begin
				if (r < 38)
					cmd = CMD_POP_HEAD;
				else if (r < 72)
					cmd = CMD_POP_TAIL;
				else if (r < 90)
					cmd = (r[0]) ? CMD_PEEK_HEAD : CMD_PEEK_TAIL;
				else
					cmd = CMD_APPEND;
			end else begin
				cmd = CMD_W'($urandom_range(5));
				if (r < 20) pos = POS_W'($urandom_range(31));
			end
			add_cmd(cmd, pos, rand_word(), idle_pct);
			issued++;
			run_left--;
		end
	endtask

	// Driver: retire the accepted transaction, then present the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			command  <= CMD_APPEND;
			position <= '0;
			data_in  <= '0;
		end else begin
			if (start && !busy) begin
				accepted_total++;
				cmd_tally[command]++;
				want = apply_list_cmd(command, position, data_in);
				if (want.ok) ok_tally++;
				pending_results.push_back(want);
			end
			if (!start || !busy) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
					next_cmd = cmd_queue.pop_front();
					start    <= 1'b1;
					command  <= next_cmd.cmd;
					position <= next_cmd.pos;
					data_in  <= next_cmd.word;
				end else
					start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe must match the oldest expected result
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_results.size() == 0)
				report_mismatch("unexpected result, count", DOUT_W'(count), '0);
			else begin
				exp_res = pending_results.pop_front();
				if (ok !== exp_res.ok)
					report_mismatch("ok", DOUT_W'(ok), DOUT_W'(exp_res.ok));
				if (data_out !== exp_res.data)
					report_mismatch("data_out", data_out, exp_res.data);
				if (count !== exp_res.count)
					report_mismatch("count", DOUT_W'(count), DOUT_W'(exp_res.count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("** bounded_deque_with_insert: FAILED **");
			$finish;
		end
	end

	initial begin
		gen_count = 0;
		// empty list first: removals and peeks must be refused; then directed inserts, appends and unused codes
		add_cmd(CMD_POP_HEAD, '0, '1, 0);
		add_cmd(CMD_POP_TAIL, '0, '1, 0);
		add_cmd(CMD_PEEK_HEAD, '0, '0, 0);
		add_cmd(CMD_PEEK_TAIL, '0, '0, 0);
		add_cmd(CMD_INSERT, 5'd1, 32'hDEAD_BEEF, 0);
		add_cmd(CMD_INSERT, 5'd0, 32'h1234_5678, 0);
		add_cmd(CMD_APPEND, '0, '1, 0);
		add_cmd(CMD_APPEND, '1, '0, 0);
		add_cmd(CMD_INSERT, 5'd3, 32'hA5A5_5A5A, 0);
		add_cmd(CMD_INSERT, 5'd0, 32'h5A5A_A5A5, 0);
		add_cmd(CMD_INSERT, 5'd31, 32'hFFFF_0000, 0);
		add_cmd(CMD_PEEK_HEAD, '0, '0, 0);
		add_cmd(CMD_PEEK_TAIL, '0, '0, 0);
		add_cmd(CMD_RSVD_6, 5'd16, '1, 0);
		add_cmd(CMD_RSVD_7, '1, '1, 0);
		add_cmd(CMD_POP_HEAD, '0, '0, 0);
		add_cmd(CMD_POP_TAIL, '0, '0, 0);
		// then random phases: no idling, sender mostly idle, no idling, light idling
		add_random_phase(0);
		add_random_phase(72);
		add_random_phase(0);
		add_random_phase(16);
		items_total = cmd_queue.size();

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (accepted_total < items_total || pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("ran %0d commands: append %0d, pop head %0d, pop tail %0d, insert %0d,",
			accepted_total, cmd_tally[CMD_APPEND], cmd_tally[CMD_POP_HEAD],
			cmd_tally[CMD_POP_TAIL], cmd_tally[CMD_INSERT]);
		$display("  peeks %0d, unused codes %0d; %0d succeeded, %0d refused full, %0d refused empty",
			cmd_tally[CMD_PEEK_HEAD] + cmd_tally[CMD_PEEK_TAIL],
			cmd_tally[CMD_RSVD_6] + cmd_tally[CMD_RSVD_7], ok_tally, full_refusals,
			empty_refusals);
		if (mismatches == 0)
			$display("** bounded_deque_with_insert: PASSED **");
		else
			$display("** bounded_deque_with_insert: FAILED **");
		$finish;
	end

endmodule

FILE: files.f
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_with_insert.sv
rtl/bdq_checker.sv
tb/bounded_deque_with_insert_test.sv
